@@ hdl/pws_pkg.sv @@
`default_nettype none
package pws_pkg;

	localparam logic [15:0] LIMIT_RESET = 16'd200;

	typedef enum logic {
		CMD_FRAME = 1'b0,
		CMD_END   = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [2:0]         present;
		logic [15:0]        tag;
	} cmd_t;

	typedef struct packed {
		logic [15:0]        tag;
		logic [2:0]         present;
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} entry_t;

	typedef struct packed {
		logic idle;
		logic steady;
		logic cnt_steady;
		logic cnt_ok;
	} back_status_t;

endpackage
`default_nettype wire

@@ hdl/pws_front.sv @@
`default_nettype none
module pws_front import pws_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [15:0] x_pos,
	input  wire logic [15:0] y_pos,
	input  wire logic [15:0] z_pos,
	input  wire logic        x_present,
	input  wire logic        y_present,
	input  wire logic        z_present,
	input  wire logic [15:0] frame_tag,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  wire logic        cmd_pop
);

	cmd_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       incoming;

	assign in_stall  = (fill_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	always_comb begin
		incoming.kind    = op ? CMD_END : CMD_FRAME;
		incoming.x       = x_pos;
		incoming.y       = y_pos;
		incoming.z       = z_pos;
		incoming.present = {z_present, y_present, x_present};
		incoming.tag     = frame_tag;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule
`default_nettype wire

@@ hdl/pws_div.sv @@
`default_nettype none
module pws_div #(
	parameter int DVD_W = 22,
	parameter int DVS_W = 6
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0]        divisor,
	output logic                         busy,
	output logic [15:0]                  quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  mag_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              ge;
	logic [DVD_W-1:0]  qs;

	assign trial    = {rem_q, mag_q[DVD_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign qs       = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quotient = qs[15:0];
	assign busy     = busy_q;

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[DVD_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			mag_q <= {mag_q[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DVD_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/pws_back.sv @@
`default_nettype none
module pws_back import pws_pkg::*; #(
	parameter int HALF_WINDOW = 30
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire cmd_t        cmd,
	output logic             cmd_pop,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      avg_x,
	output logic [15:0]      avg_y,
	output logic [15:0]      avg_z,
	output logic             write_x,
	output logic             write_y,
	output logic             write_z,
	output logic [15:0]      out_tag,
	output logic             last_out,
	output back_status_t     status
);

	localparam int WIN   = 2 * HALF_WINDOW + 1;
	localparam int IDX_W = $clog2(WIN);
	localparam int CNT_W = $clog2(WIN + 1);
	localparam int AW    = CNT_W + 1;
	localparam int SUM_W = 16 + $clog2(WIN);
	localparam logic [AW-1:0] WIN_E  = AW'(WIN);
	localparam logic [AW-1:0] HALF_E = AW'(HALF_WINDOW);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIST, ST_CMP, ST_APPEND, ST_CEN_RD,
		ST_DIV_GO, ST_DIV_WAIT, ST_OUT, ST_OLD_RD, ST_OLD_SUB
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	entry_t                  mem [WIN];
	entry_t                  rdata_q;
	entry_t                  new_ent;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        head_q;
	logic                    steady_q;
	logic                    drain_q;
	logic                    pend_q;
	logic [2:0]              dstep_q;
	logic [15:0]             lim_q;
	logic signed [SUM_W-1:0] sx_q, sy_q, sz_q;
	logic signed [15:0]      lx_q, ly_q, lz_q;
	logic signed [15:0]      fx, fy, fz;
	logic [32:0]             sq_q;
	logic [34:0]             d2_q;
	logic [31:0]             lim2_q;
	logic signed [16:0]      sq_op;
	logic signed [33:0]      sq_full;
	logic [AW-1:0]           head_e, count_e, tail_sum, cen_sum, head_inc;
	logic [IDX_W-1:0]        tail_idx, cen_idx, head_nxt, rd_idx;
	logic                    out_free;
	logic                    bx, by, bz;
	logic [15:0]             qx, qy, qz;

	assign fx = cmd_q.present[0] ? cmd_q.x : (steady_q ? lx_q : 16'sd0);
	assign fy = cmd_q.present[1] ? cmd_q.y : (steady_q ? ly_q : 16'sd0);
	assign fz = cmd_q.present[2] ? cmd_q.z : (steady_q ? lz_q : 16'sd0);

	always_comb begin
		new_ent.tag     = cmd_q.tag;
		new_ent.present = cmd_q.present;
		new_ent.x       = fx;
		new_ent.y       = fy;
		new_ent.z       = fz;
	end

	always_comb begin
		case (dstep_q)
			3'd0:    sq_op = {fx[15], fx} - {lx_q[15], lx_q};
			3'd1:    sq_op = {fy[15], fy} - {ly_q[15], ly_q};
			3'd2:    sq_op = {fz[15], fz} - {lz_q[15], lz_q};
			default: sq_op = {1'b0, lim_q};
		endcase
	end
	assign sq_full = sq_op * sq_op;

	assign head_e   = AW'(head_q);
	assign count_e  = AW'(count_q);
	assign tail_sum = head_e + count_e;
	assign cen_sum  = head_e + HALF_E;
	assign head_inc = head_e + AW'(1);
	assign tail_idx = (tail_sum >= WIN_E) ? IDX_W'(tail_sum - WIN_E) : IDX_W'(tail_sum);
	assign cen_idx  = (cen_sum >= WIN_E) ? IDX_W'(cen_sum - WIN_E) : IDX_W'(cen_sum);
	assign head_nxt = (head_inc == WIN_E) ? '0 : IDX_W'(head_inc);
	assign rd_idx   = (state_q == ST_OLD_RD) ? head_q : cen_idx;

	always_ff @(posedge clk) begin
		if (state_q == ST_APPEND) begin
			mem[tail_idx] <= new_ent;
		end
		rdata_q <= mem[rd_idx];
	end

	pws_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIV_GO),
		.dividend(sx_q), .divisor(count_q), .busy(bx), .quotient(qx)
	);
	pws_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIV_GO),
		.dividend(sy_q), .divisor(count_q), .busy(by), .quotient(qy)
	);
	pws_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(state_q == ST_DIV_GO),
		.dividend(sz_q), .divisor(count_q), .busy(bz), .quotient(qz)
	);

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		status.idle       = (state_q == ST_IDLE);
		status.steady     = steady_q;
		status.cnt_steady = (count_e == AW'(2 * HALF_WINDOW));
		status.cnt_ok     = (count_e <= WIN_E);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			d2_q  <= '0;
		end
		if (state_q == ST_DIST) begin
			sq_q <= sq_full[32:0];
			if (dstep_q != 3'd0 && dstep_q != 3'd4) begin
				d2_q <= d2_q + 35'(sq_q);
			end
			if (dstep_q == 3'd4) begin
				lim2_q <= sq_q[31:0];
			end
		end
		if (state_q == ST_APPEND) begin
			lx_q <= fx;
			ly_q <= fy;
			lz_q <= fz;
		end
		if (state_q == ST_OUT && out_free) begin
			avg_x    <= qx;
			avg_y    <= qy;
			avg_z    <= qz;
			write_x  <= rdata_q.present[0];
			write_y  <= rdata_q.present[1];
			write_z  <= rdata_q.present[2];
			out_tag  <= rdata_q.tag;
			last_out <= !drain_q || (count_e == HALF_E + AW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			head_q    <= '0;
			steady_q  <= 1'b0;
			drain_q   <= 1'b0;
			pend_q    <= 1'b0;
			dstep_q   <= '0;
			lim_q     <= LIMIT_RESET;
			sx_q      <= '0;
			sy_q      <= '0;
			sz_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					dstep_q <= '0;
					if (cmd_valid) begin
						if (cmd.kind == CMD_END) begin
							if (steady_q) begin
								drain_q <= 1'b1;
								pend_q  <= 1'b0;
								state_q <= ST_CEN_RD;
							end else begin
								count_q <= '0;
								sx_q    <= '0;
								sy_q    <= '0;
								sz_q    <= '0;
							end
						end else if (steady_q) begin
							state_q <= ST_DIST;
						end else begin
							state_q <= ST_APPEND;
						end
					end
				end
				ST_DIST: begin
					dstep_q <= dstep_q + 3'd1;
					if (dstep_q == 3'd4) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (d2_q < {3'b000, lim2_q}) begin
						state_q <= ST_APPEND;
					end else begin
						drain_q <= 1'b1;
						pend_q  <= 1'b1;
						state_q <= ST_CEN_RD;
					end
				end
				ST_APPEND: begin
					count_q <= count_q + 1'b1;
					sx_q    <= sx_q + {{(SUM_W-16){fx[15]}}, fx};
					sy_q    <= sy_q + {{(SUM_W-16){fy[15]}}, fy};
					sz_q    <= sz_q + {{(SUM_W-16){fz[15]}}, fz};
					if (steady_q || (count_e + AW'(1) == WIN_E)) begin
						state_q <= ST_CEN_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_CEN_RD:   state_q <= ST_DIV_GO;
				ST_DIV_GO:   state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (!bx && !by && !bz) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_OLD_RD;
					end
				end
				ST_OLD_RD:   state_q <= ST_OLD_SUB;
				ST_OLD_SUB: begin
					head_q  <= head_nxt;
					count_q <= count_q - 1'b1;
					sx_q    <= sx_q - {{(SUM_W-16){rdata_q.x[15]}}, rdata_q.x};
					sy_q    <= sy_q - {{(SUM_W-16){rdata_q.y[15]}}, rdata_q.y};
					sz_q    <= sz_q - {{(SUM_W-16){rdata_q.z[15]}}, rdata_q.z};
					if (drain_q) begin
						if (count_e > HALF_E + AW'(1)) begin
							state_q <= ST_CEN_RD;
						end else begin
							count_q  <= '0;
							sx_q     <= '0;
							sy_q     <= '0;
							sz_q     <= '0;
							steady_q <= 1'b0;
							drain_q  <= 1'b0;
							pend_q   <= 1'b0;
							state_q  <= pend_q ? ST_APPEND : ST_IDLE;
						end
					end else begin
						steady_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hdl/position_window_smoother_unit.sv @@
// Centered moving average over a stream of 3-D positions.
// Input channel (in_valid/in_stall): op selects a frame or end of stream;
// the frame carries x/y/z, per-axis present flags and a tag. Requests go
// into a two-deep queue, so in_stall rises only when the queue is full.
// Output channel (out_valid/out_stall): averages, write flags of the centre
// frame, its tag, and last_out on the final result of one request.
// A frame that completes the fill and every steady frame go through the
// three bit-serial dividers, each SUM_W bits wide
// (SUM_W = 16 + clog2(2*HALF_WINDOW+1), 22 by default); the distance
// check squares one axis per cycle on a shared multiplier. A drain gives
// HALF_WINDOW results. One request is executed at a time.
// cfg_we/cfg_wdata write restart_limit; write it only while idle.
// Reset clears the window, the queue and out_valid, and sets the limit
// to 200. While out_stall is high the result holds, and the back end waits
// before producing the next result; the queue keeps taking requests until full.
`default_nettype none
module position_window_smoother_unit import pws_pkg::*; #(
	parameter int HALF_WINDOW = 30
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [15:0] x_pos,
	input  wire logic [15:0] y_pos,
	input  wire logic [15:0] z_pos,
	input  wire logic        x_present,
	input  wire logic        y_present,
	input  wire logic        z_present,
	input  wire logic [15:0] frame_tag,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      avg_x,
	output logic [15:0]      avg_y,
	output logic [15:0]      avg_z,
	output logic             write_x,
	output logic             write_y,
	output logic             write_z,
	output logic [15:0]      out_tag,
	output logic             last_out
);

	logic         cmd_valid;
	cmd_t         cmd;
	logic         cmd_pop;
	back_status_t st;

	pws_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos),
		.x_present(x_present), .y_present(y_present), .z_present(z_present),
		.frame_tag(frame_tag),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	pws_back #(.HALF_WINDOW(HALF_WINDOW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.avg_x(avg_x), .avg_y(avg_y), .avg_z(avg_z),
		.write_x(write_x), .write_y(write_y), .write_z(write_z),
		.out_tag(out_tag), .last_out(last_out),
		.status(st)
	);

`ifndef SYNTHESIS
	a_steady_count: assert property (@(posedge clk) disable iff (!arst_n)
		st.idle && st.steady |-> st.cnt_steady)
		else $error("steady window does not hold 2N entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st.cnt_ok)
		else $error("window count beyond window size");

	a_drain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_out |-> !st.idle)
		else $error("back end idle with results still owed");
`endif

endmodule
`default_nettype wire
